/* src/jbq_pkg.sv */
// Shared constants, field widths, operation and mode codes, and the
// standard JPEG step tables for the block quantizer. No dependencies.
package jbq_pkg;

    // Fixed-point format of the quantizer input
    localparam int FRACTION_BITS = 4;

    // Field widths
    localparam int VALUE_W  = 16;
    localparam int RESULT_W = 19;
    localparam int POS_W    = 6;
    localparam int MODE_W   = 3;
    localparam int STEP_W   = 7;

    // Datapath widths
    localparam int MAG_W    = VALUE_W + 1;              // |value| incl. 32768
    localparam int SUM_W    = MAG_W + 2;                // 2*mag + step*2^F
    localparam int N_W      = MAG_W - FRACTION_BITS;    // pre-rounded numerator
    localparam int QSTAGE_W = 4;                        // quotient bits per stage
    localparam int Q_W      = 2 * QSTAGE_W;             // quotient (max 205)
    localparam int DVS_W    = STEP_W + QSTAGE_W;        // pre-shifted divisor
    localparam int PROD_W   = VALUE_W + STEP_W + 1;     // signed dequant product

    localparam logic signed [RESULT_W-1:0] RESULT_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic signed [RESULT_W-1:0] RESULT_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    // Operation codes
    localparam logic CMD_QUANT   = 1'b0;
    localparam logic CMD_DEQUANT = 1'b1;

    // Step table modes; unused codes fall back to the standard tables
    localparam logic [MODE_W-1:0] MODE_STD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FLAT20  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FLAT100 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_L20_C80 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_L80_C20 = 3'd4;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_20  = 7'd20;
    localparam step_t STEP_80  = 7'd80;
    localparam step_t STEP_100 = 7'd100;

    // Standard JPEG luma table, row-major
    localparam step_t STD_LUMA [64] = '{
        7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
        7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
        7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
        7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
        7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
        7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
        7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
        7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
    };

    // Standard JPEG chroma table, row-major
    localparam step_t STD_CHROMA [64] = '{
        7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
    };

endpackage

/* src/jbq_step_lut.sv */
// Step size lookup from mode, luma/chroma flag and coefficient position.
// Depends on jbq_pkg for the mode codes and standard tables.
module jbq_step_lut (
    input  logic [jbq_pkg::MODE_W-1:0] mode,
    input  logic                       is_luma,
    input  logic [jbq_pkg::POS_W-1:0]  position,
    output jbq_pkg::step_t             step
);
    import jbq_pkg::*;

    // Decode mode into a constant step or a table entry
    always_comb
    begin
        unique case (mode)
            MODE_FLAT20:  step = STEP_20;
            MODE_FLAT100: step = STEP_100;
            MODE_L20_C80: step = is_luma ? STEP_20 : STEP_80;
            MODE_L80_C20: step = is_luma ? STEP_80 : STEP_20;
            default:      step = is_luma ? STD_LUMA[position] : STD_CHROMA[position];
        endcase
    end

endmodule

/* src/jbq_div4.sv */
// Four restoring-division steps: yields four quotient bits of rem_in over a
// pre-shifted divisor and the partial remainder. Depends on jbq_pkg widths.
module jbq_div4 (
    input  logic [jbq_pkg::N_W-1:0]      rem_in,
    input  logic [jbq_pkg::DVS_W-1:0]    divisor,
    output logic [jbq_pkg::N_W-1:0]      rem_out,
    output logic [jbq_pkg::QSTAGE_W-1:0] quo
);
    import jbq_pkg::*;

    localparam int CMP_W = DVS_W + QSTAGE_W;

    // Compare and subtract, most significant quotient bit first
    always_comb
    begin
        logic [CMP_W-1:0] rem;
        logic [CMP_W-1:0] trial;
        rem = CMP_W'(rem_in);
        quo = '0;
        for (int j = QSTAGE_W - 1; j >= 0; j--)
        begin
            trial = CMP_W'(divisor) << j;
            if (rem >= trial)
            begin
                rem    = rem - trial;
                quo[j] = 1'b1;
            end
        end
        rem_out = rem[N_W-1:0];
    end

endmodule

/* src/jpeg_block_quantizer.sv */
// JPEG 8x8 coefficient quantizer/dequantizer, five-stage valid/ready pipeline.
// Depends on jbq_pkg, jbq_step_lut and jbq_div4.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  config  | cfg_we, cfg_wdata                         | in
//  input   | in_valid, in_ready, cmd, is_luma,         | in / out ready
//          | position, value                           |
//  output  | out_valid, out_ready, result              | out / in ready
//
// A result passes through stages s1 to s5 and leaves from result_reg;
// one transaction per cycle is sustained while out_ready stays high, because
// every stage, the two-stage quotient divider included, is fully pipelined.
// Reset clears all stage valid bits and sets quant_mode to standard tables.
// A stall at out_ready backs up stage by stage; in_ready drops only once all
// five stages hold an item.
module jpeg_block_quantizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [jbq_pkg::MODE_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic                                is_luma,
    input  logic [jbq_pkg::POS_W-1:0]           position,
    input  logic signed [jbq_pkg::VALUE_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [jbq_pkg::RESULT_W-1:0] result
);
    import jbq_pkg::*;

    localparam logic signed [PROD_W-1:0] PROD_MAX = PROD_W'(RESULT_MAX);
    localparam logic signed [PROD_W-1:0] PROD_MIN = PROD_W'(RESULT_MIN);

    logic [MODE_W-1:0] quant_mode_reg;

    // Stage valid bits and stage readiness
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

    // Stage 1: step, sign, magnitude
    logic                       s1_cmd_reg;
    logic                       s1_neg_reg;
    logic [MAG_W-1:0]           s1_mag_reg;
    logic signed [VALUE_W-1:0]  s1_value_reg;
    step_t                      s1_step_reg;

    // Stage 2: rounded numerator and dequant product
    logic                       s2_cmd_reg;
    logic                       s2_neg_reg;
    step_t                      s2_step_reg;
    logic [N_W-1:0]             s2_num_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;

    // Stage 3: upper quotient bits, saturated dequant result
    logic                       s3_cmd_reg;
    logic                       s3_neg_reg;
    step_t                      s3_step_reg;
    logic [N_W-1:0]             s3_rem_reg;
    logic [QSTAGE_W-1:0]        s3_qhi_reg;
    logic signed [RESULT_W-1:0] s3_deq_reg;

    // Stage 4: full quotient
    logic                       s4_cmd_reg;
    logic                       s4_neg_reg;
    logic [Q_W-1:0]             s4_quo_reg;
    logic signed [RESULT_W-1:0] s4_deq_reg;

    // Stage 5: output register
    logic signed [RESULT_W-1:0] result_reg;

    step_t                      step_lookup;
    logic [MAG_W-1:0]           mag_next;
    logic [SUM_W-1:0]           round_sum;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [RESULT_W-1:0] deq_next;
    logic [N_W-1:0]             rem_hi, rem_lo;
    logic [QSTAGE_W-1:0]        quo_hi, quo_lo;
    logic signed [RESULT_W-1:0] quo_ext;
    logic signed [RESULT_W-1:0] result_next;

    // Ready chain: a stage takes a new item when empty or draining
    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Look up the step size for the incoming transaction
    jbq_step_lut u_step_lut (
        .mode     (quant_mode_reg),
        .is_luma  (is_luma),
        .position (position),
        .step     (step_lookup)
    );

    assign mag_next = value[VALUE_W-1] ? MAG_W'(-$signed({value[VALUE_W-1], value}))
                                       : MAG_W'(value);

    // Fold round-half-away into the numerator: (2*mag + step*2^F) >> (F+1)
    assign round_sum = {1'b0, s1_mag_reg, 1'b0} + (SUM_W'(s1_step_reg) << FRACTION_BITS);
    assign prod_next = PROD_W'(s1_value_reg) * PROD_W'($signed({1'b0, s1_step_reg}));

    // Saturate dequant product
    always_comb
    begin
        if (s2_prod_reg > PROD_MAX)
            deq_next = RESULT_MAX;
        else if (s2_prod_reg < PROD_MIN)
            deq_next = RESULT_MIN;
        else
            deq_next = s2_prod_reg[RESULT_W-1:0];
    end

    // Divide, upper quotient bits against step shifted by four
    jbq_div4 u_div_hi (
        .rem_in  (s2_num_reg),
        .divisor ({s2_step_reg, {QSTAGE_W{1'b0}}}),
        .rem_out (rem_hi),
        .quo     (quo_hi)
    );

    // Divide, lower quotient bits against plain step
    jbq_div4 u_div_lo (
        .rem_in  (s3_rem_reg),
        .divisor (DVS_W'(s3_step_reg)),
        .rem_out (rem_lo),
        .quo     (quo_lo)
    );

    // Apply sign or pick dequant result
    assign quo_ext     = RESULT_W'(s4_quo_reg);
    assign result_next = (s4_cmd_reg == CMD_DEQUANT) ? s4_deq_reg
                       : (s4_neg_reg ? -quo_ext : quo_ext);

    // Hold mode register and stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_mode_reg <= MODE_STD;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                quant_mode_reg <= cfg_wdata;
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
        end
    end

    // Advance payload where the stage loads
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_cmd_reg   <= cmd;
            s1_neg_reg   <= value[VALUE_W-1];
            s1_mag_reg   <= mag_next;
            s1_value_reg <= value;
            s1_step_reg  <= step_lookup;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_step_reg <= s1_step_reg;
            s2_num_reg  <= round_sum[FRACTION_BITS+1 +: N_W];
            s2_prod_reg <= prod_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_cmd_reg  <= s2_cmd_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_step_reg <= s2_step_reg;
            s3_rem_reg  <= rem_hi;
            s3_qhi_reg  <= quo_hi;
            s3_deq_reg  <= deq_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_cmd_reg <= s3_cmd_reg;
            s4_neg_reg <= s3_neg_reg;
            s4_quo_reg <= {s3_qhi_reg, quo_lo};
            s4_deq_reg <= s3_deq_reg;
        end
        if (s5_ready && s4_valid_reg)
            result_reg <= result_next;
    end

    assign out_valid = s5_valid_reg;
    assign result    = result_reg;

    // A full pipeline with a stalled output is the only cause of backpressure
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg &&
                       s4_valid_reg && s5_valid_reg && !out_ready))
        else $error("in_ready low while pipeline has room");

    // Quotient must fit in the two divider stages
    a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_cmd_reg == CMD_QUANT) |->
            ((STEP_W + Q_W)'(s2_num_reg) < ((STEP_W + Q_W)'(s2_step_reg) << Q_W)))
        else $error("quantize numerator overflows quotient width");

    // Final remainder must be below the step
    a_rem_below_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_cmd_reg == CMD_QUANT) |->
            (rem_lo < N_W'(s3_step_reg)))
        else $error("divider remainder not below step");

    // A stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result)))
        else $error("stalled result changed");

endmodule
